// ===== rtl/core/ebwd_pkg.sv =====
package ebwd_pkg;

    // Ring and histogram sizing
    localparam int WINDOW_DEPTH = 256;
    localparam int COUNT_WIDTH  = 16;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int RCNT_W       = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int TIME_W    = 17;
    localparam int THR_W     = 9;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int WCNT_W    = 9;
    localparam int PEAK_W    = 16;
    localparam int SKIP_W    = 16;
    localparam int HOURS     = 24;

    // Time of day constants
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int MAX_HOUR     = 23;
    localparam int MAX_MIN      = 59;
    localparam int MAX_SEC      = 59;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_THRESH = 1'b1;
    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(300);
    localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(5);

    typedef struct packed {
        logic [TIME_W-1:0] window_seconds;
        logic [THR_W-1:0]  spike_threshold;
    } ebwd_cfg_t;

    // Classified event passed from front to back
    typedef struct packed {
        logic              invalid;
        logic              is_error;
        logic [HOUR_W-1:0] hour;
        logic [TIME_W-1:0] now;
    } ebwd_item_t;

endpackage

// ===== rtl/core/ebwd_if.sv =====
// Event beat channel
interface ebwd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        is_error;
    logic [ebwd_pkg::HOUR_W-1:0] hour;
    logic [ebwd_pkg::MIN_W-1:0]  minute;
    logic [ebwd_pkg::SEC_W-1:0]  second;

    modport source (output valid, is_error, hour, minute, second, input ready);
    modport sink   (input valid, is_error, hour, minute, second, output ready);
endinterface

// Result beat channel
interface ebwd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        time_invalid;
    logic                        spike_raised;
    logic [ebwd_pkg::WCNT_W-1:0] window_count;
    logic                        peak_valid;
    logic [ebwd_pkg::HOUR_W-1:0] peak_hour;
    logic [ebwd_pkg::PEAK_W-1:0] peak_count;
    logic [ebwd_pkg::SKIP_W-1:0] skipped_total;

    modport source (output valid, time_invalid, spike_raised, window_count, peak_valid,
                    peak_hour, peak_count, skipped_total, input ready);
    modport sink   (input valid, time_invalid, spike_raised, window_count, peak_valid,
                    peak_hour, peak_count, skipped_total, output ready);
endinterface

// ===== rtl/core/ebwd_front.sv =====
module ebwd_front (
    ebwd_in_if.sink                in_ch,
    output logic                   push_valid,
    output ebwd_pkg::ebwd_item_t   push_item,
    input  logic                   push_ready
);

    logic [ebwd_pkg::TIME_W-1:0] hour_sec;
    logic [ebwd_pkg::TIME_W-1:0] min_sec;

    // Handshake passes straight to the queue
    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;

    // Range check
    assign push_item.invalid = (in_ch.hour > ebwd_pkg::HOUR_W'(ebwd_pkg::MAX_HOUR))
                            || (in_ch.minute > ebwd_pkg::MIN_W'(ebwd_pkg::MAX_MIN))
                            || (in_ch.second > ebwd_pkg::SEC_W'(ebwd_pkg::MAX_SEC));
    assign push_item.is_error = in_ch.is_error;
    assign push_item.hour     = in_ch.hour;

    // Seconds of day, constant multiplies only
    assign hour_sec = ebwd_pkg::TIME_W'(in_ch.hour)
                    * ebwd_pkg::TIME_W'(ebwd_pkg::SEC_PER_HOUR);
    assign min_sec  = ebwd_pkg::TIME_W'(in_ch.minute)
                    * ebwd_pkg::TIME_W'(ebwd_pkg::SEC_PER_MIN);
    assign push_item.now = hour_sec + min_sec + ebwd_pkg::TIME_W'(in_ch.second);

endmodule

// ===== rtl/core/ebwd_queue.sv =====
module ebwd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  ebwd_pkg::ebwd_item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output ebwd_pkg::ebwd_item_t pop_item,
    input  logic                 pop_ready
);

    ebwd_pkg::ebwd_item_t            entry_reg [ebwd_pkg::QUEUE_DEPTH];
    logic [ebwd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ebwd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ebwd_pkg::QCNT_W-1:0]     fill_reg, fill_next;
    logic                            do_push, do_pop;

    assign push_ready = (fill_reg != ebwd_pkg::QCNT_W'(ebwd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ebwd_pkg::QPTR_W'(ebwd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ebwd_pkg::QPTR_W'(ebwd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/ebwd_back.sv =====
module ebwd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ebwd_pkg::ebwd_cfg_t  cfg,
    input  logic                 item_valid,
    input  ebwd_pkg::ebwd_item_t item,
    output logic                 item_ready,
    ebwd_out_if.source           out_ch
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    localparam int ADDR_W = ebwd_pkg::ADDR_W;
    localparam int RCNT_W = ebwd_pkg::RCNT_W;
    localparam int TIME_W = ebwd_pkg::TIME_W;
    localparam int CNT_W  = ebwd_pkg::COUNT_WIDTH;

    logic                          state_reg, state_next;
    logic [ADDR_W-1:0]             head_reg, head_next;
    logic [RCNT_W-1:0]             cnt_reg, cnt_next;
    logic                          armed_reg, armed_next;
    logic [TIME_W-1:0]             now_reg;
    logic [CNT_W-1:0]              hist_reg [ebwd_pkg::HOURS];
    logic [ebwd_pkg::HOUR_W-1:0]   best_hour_reg, best_hour_next;
    logic [CNT_W-1:0]              best_cnt_reg, best_cnt_next;
    logic [ebwd_pkg::SKIP_W-1:0]   skip_reg, skip_next;

    logic [TIME_W-1:0]             ring_mem [ebwd_pkg::WINDOW_DEPTH];
    logic [TIME_W-1:0]             rd_data_reg;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_inval_reg;
    logic                          out_spike_reg;
    logic [ebwd_pkg::WCNT_W-1:0]   out_wcnt_reg;
    logic [ebwd_pkg::HOUR_W-1:0]   out_phour_reg;
    logic [CNT_W-1:0]              out_pcnt_reg;
    logic [ebwd_pkg::SKIP_W-1:0]   out_skip_reg;

    logic                          out_free;
    logic                          full;
    logic [ADDR_W-1:0]             head_inc;
    logic [ADDR_W:0]               tail_sum;
    logic [ADDR_W-1:0]             tail;
    logic [TIME_W-1:0]             age;
    logic                          pop;
    logic                          ge_thr;
    logic [CNT_W-1:0]              hist_cur, hist_inc;
    logic                          push_we, hist_we, fin, fin_inval, fin_spike;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign full     = (cnt_reg == RCNT_W'(ebwd_pkg::WINDOW_DEPTH));
    assign head_inc = (head_reg == ADDR_W'(ebwd_pkg::WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Tail slot; a full ring overwrites its oldest entry
    assign tail_sum = (ADDR_W+1)'(head_reg) + (ADDR_W+1)'(cnt_reg[ADDR_W-1:0]);
    always_comb
    begin
        if (full)
        begin
            tail = head_reg;
        end
        else if (tail_sum >= (ADDR_W+1)'(ebwd_pkg::WINDOW_DEPTH))
        begin
            tail = ADDR_W'(tail_sum - (ADDR_W+1)'(ebwd_pkg::WINDOW_DEPTH));
        end
        else
        begin
            tail = ADDR_W'(tail_sum);
        end
    end

    // Front entry expiry; a lone entry is the newest and stays
    assign age    = now_reg - rd_data_reg;
    assign pop    = (cnt_reg != RCNT_W'(1)) && (rd_data_reg < now_reg)
                 && (age > cfg.window_seconds);
    assign ge_thr = 32'(cnt_reg) >= 32'(cfg.spike_threshold);

    // Saturating hour bin
    assign hist_cur = hist_reg[item.hour];
    assign hist_inc = (hist_cur == '1) ? hist_cur : hist_cur + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        armed_next     = armed_reg;
        best_hour_next = best_hour_reg;
        best_cnt_next  = best_cnt_reg;
        skip_next      = skip_reg;
        item_ready     = 1'b0;
        push_we        = 1'b0;
        hist_we        = 1'b0;
        fin            = 1'b0;
        fin_inval      = 1'b0;
        fin_spike      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.invalid || !item.is_error)
                    begin
                        if (out_free)
                        begin
                            item_ready = 1'b1;
                            fin        = 1'b1;
                            fin_inval  = item.invalid;
                            if (item.invalid && (skip_reg != '1))
                            begin
                                skip_next = skip_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        item_ready = 1'b1;
                        push_we    = 1'b1;
                        hist_we    = 1'b1;
                        head_next  = full ? head_inc : head_reg;
                        cnt_next   = full ? cnt_reg : cnt_reg + 1'b1;
                        if (hist_inc > best_cnt_reg)
                        begin
                            best_cnt_next  = hist_inc;
                            best_hour_next = item.hour;
                        end
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (pop)
                begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    fin        = 1'b1;
                    fin_spike  = ge_thr && !armed_reg;
                    armed_next = ge_thr;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = fin ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            armed_reg     <= 1'b0;
            best_hour_reg <= '0;
            best_cnt_reg  <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ebwd_pkg::HOURS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            armed_reg     <= armed_next;
            best_hour_reg <= best_hour_next;
            best_cnt_reg  <= best_cnt_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
            if (hist_we)
            begin
                hist_reg[item.hour] <= hist_inc;
            end
        end
    end

    // Time ring, registered read of the next front entry
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            ring_mem[tail] <= item.now;
        end
        rd_data_reg <= ring_mem[head_next];
    end

    // Event time and result payload
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            now_reg <= item.now;
        end
        if (fin)
        begin
            out_inval_reg <= fin_inval;
            out_spike_reg <= fin_spike;
            out_wcnt_reg  <= ebwd_pkg::WCNT_W'(cnt_reg);
            out_phour_reg <= best_hour_reg;
            out_pcnt_reg  <= best_cnt_reg;
            out_skip_reg  <= skip_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.time_invalid  = out_inval_reg;
    assign out_ch.spike_raised  = out_spike_reg;
    assign out_ch.window_count  = out_wcnt_reg;
    assign out_ch.peak_valid    = (out_pcnt_reg != '0);
    assign out_ch.peak_hour     = out_phour_reg;
    assign out_ch.peak_count    = ebwd_pkg::PEAK_W'(out_pcnt_reg);
    assign out_ch.skipped_total = out_skip_reg;

`ifndef NO_ASSERTIONS
    // Arming only happens together with a raised spike in the result register
    a_arm_with_spike: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(armed_reg) |-> (out_valid_reg && out_spike_reg))
        else $error("spike armed without a raised result");

    // The peak count never decreases
    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (best_cnt_reg >= $past(best_cnt_reg)))
        else $error("peak count decreased");

    // The ring is never empty while expiry runs
    a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (cnt_reg != '0))
        else $error("expiry on an empty ring");

    // Each expiry step drops exactly one entry
    a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && pop) |=> (cnt_reg == RCNT_W'($past(cnt_reg) - 1'b1)))
        else $error("expiry step count mismatch");
`endif

endmodule

// ===== rtl/core/error_burst_window_detector.sv =====
// Flow: a non-error or out-of-range event beat passes through the decoupling queue and
// is answered from the back-end idle state into the result register; an error beat is
// written to the ring, then the check state expires front entries, each only once, before
// its result is registered. The sequencer takes no new beat until it is back in idle.
// Reset: rst_n is asynchronous, active low; it clears counters, histogram, ring pointers
// and config to defaults (window 300 s, threshold 5). Ring contents are not cleared.
module error_burst_window_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    ebwd_in_if.sink                       in_ch,
    ebwd_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ebwd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ebwd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ebwd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [ebwd_pkg::TIME_W-1:0] window_reg;
    logic [ebwd_pkg::THR_W-1:0]  thresh_reg;
    logic                        cfg_we;
    logic                        cfg_idx;
    ebwd_pkg::ebwd_cfg_t         cfg;

    logic                        q_push_valid, q_push_ready;
    ebwd_pkg::ebwd_item_t        q_push_item;
    logic                        q_pop_valid, q_pop_ready;
    ebwd_pkg::ebwd_item_t        q_pop_item;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[ebwd_pkg::PADDR_W-1];
    assign prdata  = (cfg_idx == ebwd_pkg::CFG_THRESH) ? ebwd_pkg::PDATA_W'(thresh_reg)
                                                       : ebwd_pkg::PDATA_W'(window_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= ebwd_pkg::WINDOW_RESET;
            thresh_reg <= ebwd_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == ebwd_pkg::CFG_WINDOW)
            begin
                window_reg <= pwdata[ebwd_pkg::TIME_W-1:0];
            end
            else
            begin
                thresh_reg <= pwdata[ebwd_pkg::THR_W-1:0];
            end
        end
    end

    assign cfg.window_seconds  = window_reg;
    assign cfg.spike_threshold = thresh_reg;

    // Classify incoming events
    ebwd_front u_front (
        .in_ch      (in_ch),
        .push_valid (q_push_valid),
        .push_item  (q_push_item),
        .push_ready (q_push_ready)
    );

    // Decoupling queue
    ebwd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_item  (q_push_item),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_item   (q_pop_item),
        .pop_ready  (q_pop_ready)
    );

    // Window, histogram and spike processing
    ebwd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (q_pop_valid),
        .item       (q_pop_item),
        .item_ready (q_pop_ready),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/sv/ebwd_result_checker.sv =====
module ebwd_result_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    ebwd_in_if                           ev,
    ebwd_out_if                          res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [ebwd_pkg::PADDR_W-1:0] paddr,
    input  logic [ebwd_pkg::PDATA_W-1:0] pwdata,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ebwd_pkg::PADDR_W-1:0] WIN_ADDR = {ebwd_pkg::CFG_WINDOW, 2'b00};
    localparam logic [ebwd_pkg::PADDR_W-1:0] THR_ADDR = {ebwd_pkg::CFG_THRESH, 2'b00};

    // One predicted result beat
    typedef struct packed {
        logic                        time_invalid;
        logic                        spike_raised;
        logic [ebwd_pkg::WCNT_W-1:0] window_count;
        logic                        peak_valid;
        logic [ebwd_pkg::HOUR_W-1:0] peak_hour;
        logic [ebwd_pkg::PEAK_W-1:0] peak_count;
        logic [ebwd_pkg::SKIP_W-1:0] skipped_total;
    } event_summary_t;

    // Shadow registers
    logic [ebwd_pkg::TIME_W-1:0]      win_cfg;
    logic [ebwd_pkg::THR_W-1:0]       thr_cfg;

    // Shadow detector state
    logic [ebwd_pkg::TIME_W-1:0]      err_times [ebwd_pkg::WINDOW_DEPTH];
    logic [ebwd_pkg::ADDR_W-1:0]      oldest;
    logic [ebwd_pkg::RCNT_W-1:0]      held;
    logic                             spike_on;
    logic [ebwd_pkg::COUNT_WIDTH-1:0] hour_bins [ebwd_pkg::HOURS];
    logic [ebwd_pkg::HOUR_W-1:0]      top_hour;
    logic [ebwd_pkg::COUNT_WIDTH-1:0] top_count;
    logic [ebwd_pkg::SKIP_W-1:0]      skips;

    event_summary_t         summaries_due[$];
    event_summary_t         want;
    event_summary_t         fresh;
    int                     beat_no;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result beat %0d %s: got %0d, predicted %0d",
                                      beat_no, name, got, exp_val));
    endtask

    task automatic drop_oldest();
        oldest = (oldest == ebwd_pkg::ADDR_W'(ebwd_pkg::WINDOW_DEPTH - 1))
               ? '0 : oldest + 1'b1;
        held   = held - 1'b1;
    endtask

    // Apply one event to the shadow state and build its result beat
    task automatic predict_event(input logic err, input logic [ebwd_pkg::HOUR_W-1:0] h,
                                 input logic [ebwd_pkg::MIN_W-1:0] m,
                                 input logic [ebwd_pkg::SEC_W-1:0] s,
                                 output event_summary_t sum);
        logic                        bad;
        logic                        fired;
        logic                        done;
        logic [ebwd_pkg::TIME_W-1:0] now;
        logic [ebwd_pkg::TIME_W-1:0] front;
        logic [ebwd_pkg::ADDR_W-1:0] tail;

        bad   = (h > ebwd_pkg::MAX_HOUR) || (m > ebwd_pkg::MAX_MIN)
             || (s > ebwd_pkg::MAX_SEC);
        fired = 1'b0;
        if (bad)
        begin
            if (skips != '1)
                skips = skips + 1'b1;
        end
        else if (err)
        begin
            now = ebwd_pkg::TIME_W'(int'(h) * ebwd_pkg::SEC_PER_HOUR
                                    + int'(m) * ebwd_pkg::SEC_PER_MIN + int'(s));

            // hour histogram and peak, first to go strictly higher wins
            if (hour_bins[h] != '1)
                hour_bins[h] = hour_bins[h] + 1'b1;
            if (hour_bins[h] > top_count)
            begin
                top_count = hour_bins[h];
                top_hour  = h;
            end

            // ring full: oldest goes first
            if (held >= ebwd_pkg::WINDOW_DEPTH)
                drop_oldest();
            tail = ebwd_pkg::ADDR_W'((32'(oldest) + 32'(held)) % ebwd_pkg::WINDOW_DEPTH);
            err_times[tail] = now;
            held = held + 1'b1;

            // expire from the front; a front later than now stops it
            done = 1'b0;
            while (!done && held != 0)
            begin
                front = err_times[oldest];
                if (front < now && (now - front) > win_cfg)
                    drop_oldest();
                else
                    done = 1'b1;
            end

            // spike with hysteresis
            if (held >= thr_cfg && !spike_on)
            begin
                fired    = 1'b1;
                spike_on = 1'b1;
            end
            if (held < thr_cfg)
                spike_on = 1'b0;
        end

        sum.time_invalid  = bad;
        sum.spike_raised  = fired;
        sum.window_count  = ebwd_pkg::WCNT_W'(held);
        sum.peak_valid    = (top_count != 0);
        sum.peak_hour     = top_hour;
        sum.peak_count    = ebwd_pkg::PEAK_W'(top_count);
        sum.skipped_total = skips;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg   = ebwd_pkg::WINDOW_RESET;
            thr_cfg   = ebwd_pkg::THRESH_RESET;
            oldest    = '0;
            held      = '0;
            spike_on  = 1'b0;
            for (int i = 0; i < ebwd_pkg::HOURS; i++)
                hour_bins[i] = '0;
            top_hour  = '0;
            top_count = '0;
            skips     = '0;
            beat_no   = 0;
            fail_count = 0;
            summaries_due.delete();
            pending <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (res.valid && res.ready)
            begin
                beat_no = beat_no + 1;
                if (summaries_due.size() == 0)
                    report_mismatch($sformatf("result beat %0d with no event outstanding",
                                              beat_no));
                else
                begin
                    want = summaries_due.pop_front();
                    check_field("time_invalid", 32'(res.time_invalid),
                                32'(want.time_invalid));
                    check_field("spike_raised", 32'(res.spike_raised),
                                32'(want.spike_raised));
                    check_field("window_count", 32'(res.window_count),
                                32'(want.window_count));
                    check_field("peak_valid", 32'(res.peak_valid), 32'(want.peak_valid));
                    check_field("peak_hour", 32'(res.peak_hour), 32'(want.peak_hour));
                    check_field("peak_count", 32'(res.peak_count), 32'(want.peak_count));
                    check_field("skipped_total", 32'(res.skipped_total),
                                32'(want.skipped_total));
                end
            end

            // event beat
            if (ev.valid && ev.ready)
            begin
                predict_event(ev.is_error, ev.hour, ev.minute, ev.second, fresh);
                summaries_due = {summaries_due, fresh};
            end

            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == WIN_ADDR)
                    win_cfg = pwdata[ebwd_pkg::TIME_W-1:0];
                else if (paddr == THR_ADDR)
                    thr_cfg = pwdata[ebwd_pkg::THR_W-1:0];
            end

            pending <= summaries_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_error_burst_window_detector.sv =====
module tb_error_burst_window_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ebwd_pkg::PADDR_W-1:0] WIN_ADDR = {ebwd_pkg::CFG_WINDOW, 2'b00};
    localparam logic [ebwd_pkg::PADDR_W-1:0] THR_ADDR = {ebwd_pkg::CFG_THRESH, 2'b00};
    localparam int DAY_SECONDS = 86400;
    localparam int PHASES = 8;

    // Per phase: window, threshold, event count, largest time step.
    // A negative window or threshold means pick one at random.
    localparam int PH_WIN  [PHASES] = '{86399, 300, 0, 131071, 10, -1, 60, 3600};
    localparam int PH_THR  [PHASES] = '{256, 5, 0, 511, 2, -1, 1, 256};
    localparam int PH_N    [PHASES] = '{400, 200, 150, 150, 150, 200, 150, 150};
    localparam int PH_STEP [PHASES] = '{3, 60, 1, 20, 5, 40, 30, 100};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ebwd_pkg::PADDR_W-1:0]  paddr;
    logic [ebwd_pkg::PDATA_W-1:0]  pwdata;
    logic [ebwd_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    int                  fail_count;
    int                  pending;

    // sender idling state
    bit                  tx_calm;
    int                  tx_stretch;
    // receiver idling state
    bit                  rx_calm;
    int                  rx_stretch;
    int                  rx_stall;

    ebwd_in_if  ev_if ();
    ebwd_out_if res_if ();

    error_burst_window_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (ev_if),
        .out_ch  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ebwd_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev_if),
        .res        (res_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5ns clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure, with calm stretches of no stalls
    always @(posedge clk)
    begin
        if (rx_stretch == 0)
        begin
            rx_stretch = 300;
            rx_calm    = ($urandom_range(0, 3) == 0);
        end
        rx_stretch = rx_stretch - 1;
        if (rx_stall > 0)
        begin
            rx_stall = rx_stall - 1;
            res_if.ready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 30)
        begin
            rx_stall = pick_gap();
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= 1'b1;
    end

    // One event beat; valid stays up into the next beat when no gap follows
    task automatic send_event(input logic err, input logic [ebwd_pkg::HOUR_W-1:0] h,
                              input logic [ebwd_pkg::MIN_W-1:0] m,
                              input logic [ebwd_pkg::SEC_W-1:0] s);
        int gap;
        ev_if.valid    <= 1'b1;
        ev_if.is_error <= err;
        ev_if.hour     <= h;
        ev_if.minute   <= m;
        ev_if.second   <= s;
        @(posedge clk);
        while (!ev_if.ready)
            @(posedge clk);
        if (tx_stretch == 0)
        begin
            tx_stretch = 40;
            tx_calm    = ($urandom_range(0, 3) == 0);
        end
        tx_stretch = tx_stretch - 1;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Setup and access phases, then idle with psel low before the next transfer
    task automatic apb_write(input logic [ebwd_pkg::PADDR_W-1:0] addr,
                             input logic [ebwd_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Junk above the field width must be dropped by the register
    task automatic set_config(input int win, input int thr);
        apb_write(WIN_ADDR, ($urandom & ~32'h1FFFF) | ebwd_pkg::PDATA_W'(win));
        apb_write(THR_ADDR, ($urandom & ~32'h1FF) | ebwd_pkg::PDATA_W'(thr));
    endtask

    // Stop sending and wait for every outstanding result beat
    task automatic drain();
        ev_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly a running clock of events, some noise, some jumps back in time
    task automatic run_phase(input int n_items, input int step_max);
        int   t;
        int   r;
        logic err;
        logic [ebwd_pkg::HOUR_W-1:0] h;
        logic [ebwd_pkg::MIN_W-1:0]  m;
        logic [ebwd_pkg::SEC_W-1:0]  s;
        t = $urandom_range(0, 40000);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 88)
            begin
                t = t + $urandom_range(0, step_max);
                if (t >= DAY_SECONDS)
                    t = t - DAY_SECONDS;
                h   = ebwd_pkg::HOUR_W'(t / ebwd_pkg::SEC_PER_HOUR);
                m   = ebwd_pkg::MIN_W'((t / ebwd_pkg::SEC_PER_MIN) % 60);
                s   = ebwd_pkg::SEC_W'(t % 60);
                err = ($urandom_range(0, 9) < 8);
            end
            else if (r < 96)
            begin
                err = 1'($urandom_range(0, 1));
                h   = ebwd_pkg::HOUR_W'($urandom_range(0, 31));
                m   = ebwd_pkg::MIN_W'($urandom_range(0, 63));
                s   = ebwd_pkg::SEC_W'($urandom_range(0, 63));
            end
            else
            begin
                err = 1'b1;
                h   = ebwd_pkg::HOUR_W'($urandom_range(0, ebwd_pkg::MAX_HOUR));
                m   = ebwd_pkg::MIN_W'($urandom_range(0, ebwd_pkg::MAX_MIN));
                s   = ebwd_pkg::SEC_W'($urandom_range(0, ebwd_pkg::MAX_SEC));
            end
            send_event(err, h, m, s);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        ev_if.valid    = 1'b0;
        ev_if.is_error = 1'b0;
        ev_if.hour     = '0;
        ev_if.minute   = '0;
        ev_if.second   = '0;
        res_if.ready   = 1'b0;
        tx_calm        = 1'b0;
        tx_stretch     = 0;
        rx_calm        = 1'b0;
        rx_stretch     = 0;
        rx_stall       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings (window 300 s, threshold 5)
        send_event(1'b0, 5'd0, 6'd0, 6'd0);      // non-error, nothing changes
        send_event(1'b1, 5'd24, 6'd0, 6'd0);     // hour out of range, error flag ignored
        send_event(1'b0, 5'd31, 6'd63, 6'd63);   // all fields at top
        send_event(1'b1, 5'd12, 6'd60, 6'd0);    // minute out of range
        send_event(1'b1, 5'd12, 6'd0, 6'd60);    // second out of range
        send_event(1'b1, 5'd1, 6'd0, 6'd0);
        send_event(1'b1, 5'd1, 6'd0, 6'd10);
        send_event(1'b1, 5'd1, 6'd0, 6'd20);
        send_event(1'b1, 5'd1, 6'd0, 6'd30);
        send_event(1'b1, 5'd1, 6'd0, 6'd40);     // count reaches threshold: spike
        send_event(1'b1, 5'd1, 6'd0, 6'd50);     // still above: no second spike
        send_event(1'b1, 5'd1, 6'd10, 6'd0);     // window empties, re-arm
        send_event(1'b0, 5'd1, 6'd10, 6'd1);
        repeat (5)
            send_event(1'b1, 5'd2, 6'd0, 6'd0);  // same second, spike again
        send_event(1'b1, 5'd23, 6'd59, 6'd59);   // latest time of day
        send_event(1'b1, 5'd0, 6'd0, 6'd0);      // time going backwards
        send_event(1'b1, 5'd0, 6'd0, 6'd0);
        send_event(1'b1, 5'd23, 6'd0, 6'd59);
        drain();

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++)
        begin
            set_config(PH_WIN[p] < 0 ? $urandom_range(0, 1000) : PH_WIN[p],
                       PH_THR[p] < 0 ? $urandom_range(1, 30) : PH_THR[p]);
            run_phase(PH_N[p], PH_STEP[p]);
            drain();
        end

        // let any stray beat show up before the verdict
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("error_burst_window_detector regression: pass");
        else
            $display("error_burst_window_detector regression: fail");
        $finish;
    end

    // Hang guard
    initial
    begin
        #10ms;
        $display("error_burst_window_detector regression: fail");
        $finish;
    end

endmodule
